FILE: src/btlpm_pkg.sv
// Package for the binary trie longest prefix match block.
// Holds shared constants: status and function codes, field widths, defaults.
// No dependencies.
`default_nettype none
package btlpm_pkg;
	localparam int NODE_COUNT_DEF    = 4096;
	localparam int ADDRESS_WIDTH_DEF = 32;
	localparam int IFACE_W           = 10;
	localparam int CFG_W             = 11;
	localparam int PLEN_W            = 6;
	localparam int STATUS_W          = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DISCARD = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	localparam logic signed [CFG_W-1:0] DEFAULT_IFACE_RST = -11'sd1;
endpackage
`default_nettype wire

FILE: src/btlpm_cell.sv
// One cell of the address bit chain: holds one bit, loads or shifts to its neighbor.
// Depends on nothing.
`default_nettype none
module btlpm_cell (
	input  wire logic clk,
	input  wire logic load,
	input  wire logic shift,
	input  wire logic load_bit,
	input  wire logic prev_bit,
	output logic      bit_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= prev_bit;
		end
	end
endmodule
`default_nettype wire

FILE: src/btlpm_node_ram.sv
// Trie node memory: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none
module btlpm_node_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 35
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: src/binary_trie_longest_prefix_match.sv
// Top level of the binary trie longest prefix match block.
// Depends on btlpm_pkg, btlpm_cell and btlpm_node_ram.
//
// IPv4 forwarding table held as a binary trie. An insert item walks its prefix
// from the root; where the path ends it writes the new nodes one per cycle and
// marks the last one with the route interface. A lookup item walks the address
// and returns the interface of the deepest marked node it passes, else the
// default interface, else a discard status. The root node lives in flip-flops and
// is cleared by reset; all other nodes are in a single-port-write memory and are
// written before they are ever read, so no clearing pass is needed. The address
// bits move through a chain of one-bit cells, the head cell giving the branch bit.
// Sequence: IDLE accepts the item, WALK walks the trie one level per memory read,
// FILL writes each newly allocated node on insert, and DONE hands the result to the
// output register once it is free. One item is in work at a time; the next item
// is accepted as soon as the result sits in the output register.
`default_nettype none
module binary_trie_longest_prefix_match #(
	parameter int NODE_COUNT    = btlpm_pkg::NODE_COUNT_DEF,
	parameter int ADDRESS_WIDTH = btlpm_pkg::ADDRESS_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic signed [btlpm_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 func,
	input  wire logic [ADDRESS_WIDTH-1:0]             address_bits,
	input  wire logic [btlpm_pkg::PLEN_W-1:0]         prefix_length,
	input  wire logic [btlpm_pkg::IFACE_W-1:0]        route_interface,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [btlpm_pkg::STATUS_W-1:0]       status,
	output logic      [btlpm_pkg::IFACE_W-1:0]        next_hop
);
	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int CNT_W  = $clog2(NODE_COUNT + 1);
	localparam int LEN_W  = $clog2(ADDRESS_WIDTH + 1);
	localparam int IF_W   = btlpm_pkg::IFACE_W;
	localparam int NODE_W = 2 * IDX_W + 1 + IF_W;
	// node layout: left child, right child, route valid, interface
	localparam int L_HI = NODE_W - 1;
	localparam int R_HI = NODE_W - 1 - IDX_W;
	localparam int V_B  = IF_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]                         state_q;
	logic                               func_q;
	logic [LEN_W-1:0]                   len_q;
	logic [LEN_W-1:0]                   depth_q;
	logic [IF_W-1:0]                    iface_q;
	logic [IF_W-1:0]                    best_q;
	logic                               found_q;
	logic [CNT_W-1:0]                   used_q;
	logic [NODE_W-1:0]                  root_q;
	logic                               cur_root_q;
	logic [IDX_W-1:0]                   cur_idx_q;
	logic signed [btlpm_pkg::CFG_W-1:0] dflt_q;
	logic [btlpm_pkg::STATUS_W-1:0]     res_status_q;
	logic [IF_W-1:0]                    res_hop_q;

	logic [ADDRESS_WIDTH-1:0] chain;
	logic                     head;
	logic                     accept;
	logic                     step;
	logic                     alloc;
	logic [NODE_W-1:0]        rd_data;
	logic [NODE_W-1:0]        cur;
	logic [IDX_W-1:0]         child;
	logic                     at_end;
	logic                     best_v;
	logic [IF_W-1:0]          best_i;
	logic [CNT_W:0]           need;
	logic                     full;
	logic                     we;
	logic [IDX_W-1:0]         waddr;
	logic [NODE_W-1:0]        wdata;
	logic                     root_we;
	logic                     re;
	logic [LEN_W-1:0]         len_in;
	logic                     out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// address bit chain, head cell holds the branch bit of the current depth
	assign head = chain[ADDRESS_WIDTH-1];
	genvar g;
	generate
		for (g = 0; g < ADDRESS_WIDTH; g++) begin : g_cell
			btlpm_cell u_cell (
				.clk      (clk),
				.load     (accept),
				.shift    (step),
				.load_bit (address_bits[g]),
				.prev_bit ((g == 0) ? 1'b0 : chain[(g == 0) ? 0 : g - 1]),
				.bit_q    (chain[g])
			);
		end
	endgenerate

	always_comb begin
		if (int'(prefix_length) > ADDRESS_WIDTH) begin
			len_in = LEN_W'(ADDRESS_WIDTH);
		end else begin
			len_in = LEN_W'(prefix_length);
		end
	end

	assign cur    = cur_root_q ? root_q : rd_data;
	assign child  = head ? cur[R_HI -: IDX_W] : cur[L_HI -: IDX_W];
	assign at_end = (depth_q == len_q);
	assign best_v = found_q || cur[V_B];
	assign best_i = cur[V_B] ? cur[IF_W-1:0] : best_q;
	assign need   = {1'b0, used_q} + (CNT_W + 1)'(len_q - depth_q);
	assign full   = need > (CNT_W + 1)'(NODE_COUNT);

	// walk reads the next level when a child exists and the path is not done
	assign re    = (state_q == S_WALK) && !at_end && (child != '0);
	// insert path ends here: link the first new node and start filling
	assign alloc = (state_q == S_WALK) && (func_q == btlpm_pkg::FUNC_INSERT)
		&& (len_q != '0) && !at_end && (child == '0) && !full;
	// advance the bit chain on every level that moves one deeper
	assign step  = re || alloc || (state_q == S_FILL);

	// node writes: end of existing path on insert, then each new node
	always_comb begin
		we      = 1'b0;
		root_we = 1'b0;
		waddr   = cur_idx_q;
		wdata   = cur;
		if (state_q == S_WALK && func_q == btlpm_pkg::FUNC_INSERT && len_q != '0) begin
			if (at_end) begin
				wdata[V_B]         = 1'b1;
				wdata[IF_W-1:0]    = iface_q;
				we                 = !cur_root_q;
				root_we            = cur_root_q;
			end else if (child == '0 && !full) begin
				if (head) begin
					wdata[R_HI -: IDX_W] = used_q[IDX_W-1:0];
				end else begin
					wdata[L_HI -: IDX_W] = used_q[IDX_W-1:0];
				end
				we      = !cur_root_q;
				root_we = cur_root_q;
			end
		end else if (state_q == S_FILL) begin
			waddr = used_q[IDX_W-1:0];
			wdata = '0;
			we    = 1'b1;
			if (at_end) begin
				wdata[V_B]      = 1'b1;
				wdata[IF_W-1:0] = iface_q;
			end else if (head) begin
				wdata[R_HI -: IDX_W] = IDX_W'(used_q + CNT_W'(1));
			end else begin
				wdata[L_HI -: IDX_W] = IDX_W'(used_q + CNT_W'(1));
			end
		end
	end

	btlpm_node_ram #(
		.DEPTH (NODE_COUNT),
		.WIDTH (NODE_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (child),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= CNT_W'(1);
			root_q     <= '0;
			dflt_q     <= btlpm_pkg::DEFAULT_IFACE_RST;
			out_valid  <= 1'b0;
			cur_root_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				dflt_q <= cfg_wdata;
			end
			if (root_we) begin
				root_q <= wdata;
			end
			// load a finished result, or drop the one just taken
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_WALK;
						cur_root_q <= 1'b1;
					end
				end
				S_WALK: begin
					if (func_q == btlpm_pkg::FUNC_LOOKUP) begin
						if (at_end || child == '0) begin
							state_q <= S_DONE;
						end else begin
							cur_root_q <= 1'b0;
						end
					end else if (len_q == '0 || at_end) begin
						state_q <= S_DONE;
					end else if (child == '0) begin
						if (full) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_FILL;
						end
					end else begin
						cur_root_q <= 1'b0;
					end
				end
				S_FILL: begin
					used_q <= used_q + CNT_W'(1);
					if (at_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			len_q   <= (func == btlpm_pkg::FUNC_LOOKUP) ? LEN_W'(ADDRESS_WIDTH) : len_in;
			depth_q <= '0;
			iface_q <= route_interface;
			found_q <= !dflt_q[btlpm_pkg::CFG_W-1];
			best_q  <= dflt_q[IF_W-1:0];
		end
		if (state_q == S_WALK) begin
			if (step) begin
				cur_idx_q <= child;
				depth_q   <= depth_q + LEN_W'(1);
			end else if (child == '0 && !at_end) begin
				depth_q <= depth_q + LEN_W'(1);
			end
			found_q <= best_v;
			best_q  <= best_i;
			if (func_q == btlpm_pkg::FUNC_LOOKUP) begin
				res_status_q <= best_v ? btlpm_pkg::ST_OK : btlpm_pkg::ST_DISCARD;
				res_hop_q    <= best_v ? best_i : '0;
			end else begin
				res_status_q <= (len_q != '0 && !at_end && child == '0 && full)
					? btlpm_pkg::ST_FULL : btlpm_pkg::ST_OK;
				res_hop_q    <= '0;
			end
		end
		if (state_q == S_FILL && !at_end) begin
			depth_q <= depth_q + LEN_W'(1);
		end
		if (state_q == S_DONE && out_free) begin
			status   <= res_status_q;
			next_hop <= res_hop_q;
		end
	end

	// the allocator never hands out more nodes than the store holds
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q >= CNT_W'(1)) && ({1'b0, used_q} <= (CNT_W + 1)'(NODE_COUNT)))
		else $error("node count out of range");

	// new nodes are allocated only for inserts
	a_fill_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (func_q == btlpm_pkg::FUNC_INSERT))
		else $error("node fill during lookup");

	// an accepted item always starts a walk
	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_WALK))
		else $error("accepted item did not start a walk");

	// a result is loaded only when the walk is finished
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_DONE))
		else $error("result loaded outside done state");
endmodule
`default_nettype wire
